[src/rbst_pkg.sv]
package rbst_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_AXES    = 3;
  localparam int NUM_LANES   = 2 * NUM_AXES;
  localparam int DIV_STAGES  = (COORD_WIDTH + 1) / 2;
  localparam int NUM_STAGES  = DIV_STAGES + 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = CFG_IDX_W'(5);

  localparam logic [COORD_WIDTH-1:0] POS_LIMIT = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] NEG_LIMIT = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic [COORD_WIDTH:0]   nmag;
    logic [COORD_WIDTH-1:0] dmag;
    logic [COORD_WIDTH-1:0] rem;
    logic [COORD_WIDTH-1:0] quo;
    logic                   neg;
    logic                   sat;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_LANES-1:0] lane;
    logic [NUM_AXES-1:0]   zero;
    logic [NUM_AXES-1:0]   in_box;
  } divp_t;

  typedef struct packed {
    coord_t [NUM_AXES-1:0] t_lo;
    coord_t [NUM_AXES-1:0] t_hi;
    logic [NUM_AXES-1:0]   zero;
    logic [NUM_AXES-1:0]   in_box;
  } slab_t;

  typedef struct packed {
    coord_t lo;
    coord_t hi;
    logic   have;
    logic   hit;
    coord_t t_lo_z;
    coord_t t_hi_z;
    logic   zero_z;
    logic   inside_z;
  } merge_t;

  function automatic lane_t lane_prep(coord_t bound, coord_t org, coord_t dir);
    logic signed [COORD_WIDTH:0] diff;
    logic [COORD_WIDTH:0] top;
    lane_t l;
    diff = {bound[COORD_WIDTH-1], bound} - {org[COORD_WIDTH-1], org};
    l.nmag = diff[COORD_WIDTH] ? (COORD_WIDTH+1)'(-diff) : diff;
    l.dmag = dir[COORD_WIDTH-1] ? COORD_WIDTH'(-dir) : dir;
    l.neg  = diff[COORD_WIDTH] ^ dir[COORD_WIDTH-1];
    top    = l.nmag >> (COORD_WIDTH - FRAC_BITS);
    l.sat  = top >= {1'b0, l.dmag};
    l.rem  = top[COORD_WIDTH-1:0];
    l.quo  = '0;
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, int i);
    logic nbit;
    logic [COORD_WIDTH-1:0] sh;
    logic ge;
    lane_t o;
    o = l;
    nbit = (i >= FRAC_BITS) ? l.nmag[i - FRAC_BITS] : 1'b0;
    sh = {l.rem[COORD_WIDTH-2:0], nbit};
    ge = sh >= l.dmag;
    o.rem = ge ? sh - l.dmag : sh;
    o.quo = {l.quo[COORD_WIDTH-2:0], ge};
    return o;
  endfunction

  function automatic divp_t div_step(divp_t d, int i);
    divp_t o;
    o = d;
    for (int n = 0; n < NUM_LANES; n++) begin
      o.lane[n] = lane_step(d.lane[n], i);
    end
    return o;
  endfunction

  function automatic coord_t lane_result(lane_t l);
    logic [COORD_WIDTH-1:0] m;
    if (l.neg) begin
      m = (l.sat || l.quo > NEG_LIMIT) ? NEG_LIMIT : l.quo;
      return coord_t'(-m);
    end
    m = (l.sat || l.quo > POS_LIMIT) ? POS_LIMIT : l.quo;
    return coord_t'(m);
  endfunction

  function automatic merge_t merge_axis(merge_t s, coord_t t0, coord_t t1,
                                        logic zero, logic in_box);
    merge_t o;
    o = s;
    if (s.hit) begin
      if (zero) begin
        o.hit = in_box;
      end else if (!s.have) begin
        o.lo = t0;
        o.hi = t1;
        o.have = 1'b1;
      end else if (s.lo > t1 || t0 > s.hi) begin
        o.hit = 1'b0;
      end else begin
        if (t0 > s.lo) o.lo = t0;
        if (t1 < s.hi) o.hi = t1;
      end
    end
    return o;
  endfunction

endpackage

[src/ray_box_slab_test_core.sv]
// Ray against axis-aligned box test by the slab method in signed Q16.16. The box is held in
// six configuration registers; the user must write them only while the block is idle; the
// block does not enforce this. One ray is taken per cycle while in_stall is low, and one hit
// bit per ray comes out in order. The stages: a prep stage forms the slab numerators and
// direction magnitudes, six restoring dividers run two quotient bits per stage over sixteen
// stages, one stage saturates and orders the slab parameters, and two stages narrow the
// interval. Each stage holds its item only while the next one is full, so bubbles close up
// under stall.
module ray_box_slab_test_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rbst_pkg::coord_t               origin_x,
  input  rbst_pkg::coord_t               origin_y,
  input  rbst_pkg::coord_t               origin_z,
  input  rbst_pkg::coord_t               dir_x,
  input  rbst_pkg::coord_t               dir_y,
  input  rbst_pkg::coord_t               dir_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  rbst_pkg::coord_t               cfg_data
);
  import rbst_pkg::*;

  coord_t box_min [NUM_AXES];
  coord_t box_max [NUM_AXES];

  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] adv;
  divp_t  prep_next;
  divp_t  p [DIV_STAGES+1];
  divp_t  p_next [DIV_STAGES+1];
  slab_t  s1;
  slab_t  s1_next;
  merge_t m2;
  merge_t m2_next;
  merge_t m3_next;
  coord_t org [NUM_AXES];
  coord_t dir [NUM_AXES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        box_min[a] <= '0;
        box_max[a] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOX_MIN_X: box_min[0] <= cfg_data;
        REG_BOX_MAX_X: box_max[0] <= cfg_data;
        REG_BOX_MIN_Y: box_min[1] <= cfg_data;
        REG_BOX_MAX_Y: box_max[1] <= cfg_data;
        REG_BOX_MIN_Z: box_min[2] <= cfg_data;
        REG_BOX_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage advance chain, last stage frees when the result transfer happens
  always_comb begin
    adv[NUM_STAGES-1] = !v[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  // prep stage
  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  always_comb begin
    prep_next = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      prep_next.lane[2*a]   = lane_prep(box_min[a], org[a], dir[a]);
      prep_next.lane[2*a+1] = lane_prep(box_max[a], org[a], dir[a]);
      prep_next.zero[a]     = dir[a] == '0;
      prep_next.in_box[a]   = org[a] >= box_min[a] && org[a] <= box_max[a];
    end
  end

  assign p_next[0] = prep_next;

  // divider stages, two quotient bits each
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    localparam int B0 = COORD_WIDTH - 1 - 2 * (k - 1);
    localparam int B1 = B0 - 1;
    if (B1 >= 0) begin : g_two
      assign p_next[k] = div_step(div_step(p[k-1], B0), B1);
    end else begin : g_one
      assign p_next[k] = div_step(p[k-1], B0);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (adv[k]) p[k] <= p_next[k];
    end
  end

  // saturate, sign and order
  always_comb begin
    coord_t ta;
    coord_t tb;
    s1_next = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      ta = lane_result(p[DIV_STAGES].lane[2*a]);
      tb = lane_result(p[DIV_STAGES].lane[2*a+1]);
      s1_next.t_lo[a] = (ta > tb) ? tb : ta;
      s1_next.t_hi[a] = (ta > tb) ? ta : tb;
    end
    s1_next.zero   = p[DIV_STAGES].zero;
    s1_next.in_box = p[DIV_STAGES].in_box;
  end

  always_ff @(posedge clk) begin
    if (adv[DIV_STAGES+1]) s1 <= s1_next;
  end

  // x then y
  always_comb begin
    merge_t m;
    m = '0;
    m.hit = 1'b1;
    m = merge_axis(m, s1.t_lo[0], s1.t_hi[0], s1.zero[0], s1.in_box[0]);
    m = merge_axis(m, s1.t_lo[1], s1.t_hi[1], s1.zero[1], s1.in_box[1]);
    m.t_lo_z   = s1.t_lo[2];
    m.t_hi_z   = s1.t_hi[2];
    m.zero_z   = s1.zero[2];
    m.inside_z = s1.in_box[2];
    m2_next = m;
  end

  always_ff @(posedge clk) begin
    if (adv[DIV_STAGES+2]) m2 <= m2_next;
  end

  // z and result register
  assign m3_next = merge_axis(m2, m2.t_lo_z, m2.t_hi_z, m2.zero_z, m2.inside_z);

  always_ff @(posedge clk) begin
    if (adv[NUM_STAGES-1]) hit <= m3_next.hit;
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&v))
    else $error("input stalled while pipeline has a free stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v[0])
    else $error("accepted ray not captured in prep stage");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    v[0] && !adv[0] |=> v[0])
    else $error("held prep stage item lost");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit))
    else $error("stalled result dropped or changed");

endmodule

[dv/ray_box_slab_test_core_test.sv]
module ray_box_slab_test_core_test;
  import rbst_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam longint unsigned PLIM = (64'd1 << (CW - 1)) - 1;
  localparam int LATENCY = NUM_STAGES + 4;
  localparam longint CYCLE_LIMIT = 400000;

  class hit_scoreboard;
    longint bmin[3];
    longint bmax[3];
    bit expected_hits[$];
    int mismatches;
    int checked;

    function new();
      for (int a = 0; a < 3; a++) begin
        bmin[a] = 0;
        bmax[a] = 0;
      end
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_bound(logic [CFG_IDX_W-1:0] idx, coord_t v);
      case (idx)
        REG_BOX_MIN_X: bmin[0] = longint'(v);
        REG_BOX_MAX_X: bmax[0] = longint'(v);
        REG_BOX_MIN_Y: bmin[1] = longint'(v);
        REG_BOX_MAX_Y: bmax[1] = longint'(v);
        REG_BOX_MIN_Z: bmin[2] = longint'(v);
        REG_BOX_MAX_Z: bmax[2] = longint'(v);
        default: ;
      endcase
    endfunction

    function longint slab_param(longint bound, longint org, longint dir);
      longint unsigned nmag, dmag, q, r, lim;
      bit neg;
      bit done;
      nmag = bound >= org ? unsigned'(bound - org) : unsigned'(org - bound);
      dmag = dir < 0 ? unsigned'(-dir) : unsigned'(dir);
      neg = (bound < org) != (dir < 0);
      lim = neg ? PLIM + 1 : PLIM;
      q = nmag / dmag;
      r = nmag % dmag;
      done = 0;
      if (q > lim) begin
        q = lim;
        done = 1;
      end
      for (int i = 0; i < FRAC_BITS && !done; i++) begin
        if (q > (lim >> 1)) begin
          q = lim;
          done = 1;
        end else begin
          r = r << 1;
          q = q << 1;
          if (r >= dmag) begin
            r -= dmag;
            q |= 1;
          end
          if (q > lim) begin
            q = lim;
            done = 1;
          end
        end
      end
      return neg ? -longint'(q) : longint'(q);
    endfunction

    function void note_ray(coord_t o[3], coord_t d[3]);
      longint lo, hi, t0, t1, s;
      bit have, h;
      have = 0;
      h = 1;
      lo = 0;
      hi = 0;
      for (int a = 0; a < 3 && h; a++) begin
        if (d[a] == 0) begin
          if (longint'(o[a]) < bmin[a] || longint'(o[a]) > bmax[a]) h = 0;
        end else begin
          t0 = slab_param(bmin[a], longint'(o[a]), longint'(d[a]));
          t1 = slab_param(bmax[a], longint'(o[a]), longint'(d[a]));
          if (t0 > t1) begin
            s = t0;
            t0 = t1;
            t1 = s;
          end
          if (!have) begin
            lo = t0;
            hi = t1;
            have = 1;
          end else if (lo > t1 || t0 > hi) begin
            h = 0;
          end else begin
            if (t0 > lo) lo = t0;
            if (t1 < hi) hi = t1;
          end
        end
      end
      expected_hits.insert(expected_hits.size(), h);
    endfunction

    function void check_hit(logic actual);
      bit e;
      checked++;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0b", actual);
        return;
      end
      e = expected_hits.pop_front();
      if (actual !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("hit mismatch: expected %0b actual %0b", e, actual);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  coord_t origin_x = '0, origin_y = '0, origin_z = '0;
  coord_t dir_x = '0, dir_y = '0, dir_z = '0;
  logic out_valid;
  logic out_stall = 0;
  logic hit;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  coord_t cfg_data = '0;

  hit_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;
  int rays_sent = 0;

  ray_box_slab_test_core u_top (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) sb.check_hit(hit);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // leaves cfg_valid high, caller drops it
  task automatic write_bound(logic [CFG_IDX_W-1:0] idx, coord_t v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_bound(idx, v);
    @(negedge clk);
  endtask

  task automatic set_box(coord_t x0, coord_t x1, coord_t y0, coord_t y1, coord_t z0, coord_t z1);
    write_bound(REG_BOX_MIN_X, x0);
    write_bound(REG_BOX_MAX_X, x1);
    write_bound(REG_BOX_MIN_Y, y0);
    write_bound(REG_BOX_MAX_Y, y1);
    write_bound(REG_BOX_MIN_Z, z0);
    write_bound(REG_BOX_MAX_Z, z1);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (sb.expected_hits.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // call at negedge
  task automatic send_ray(coord_t ox, coord_t oy, coord_t oz, coord_t dx, coord_t dy, coord_t dz);
    coord_t o[3];
    coord_t d[3];
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    origin_x <= ox;
    origin_y <= oy;
    origin_z <= oz;
    dir_x <= dx;
    dir_y <= dy;
    dir_z <= dz;
    o = '{ox, oy, oz};
    d = '{dx, dy, dz};
    do @(posedge clk); while (in_stall);
    sb.note_ray(o, d);
    rays_sent++;
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord(bit near);
    case ($urandom_range(near ? 5 : 3))
      0: return coord_t'($urandom);
      1: return coord_t'({$urandom_range(1) ? 32'h80000000 : 32'h7fffffff});
      2: return coord_t'(0);
      3: return coord_t'(32'sd65536 * ($urandom_range(20) - 10));
      default: return coord_t'(int'($urandom_range(1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic coord_t rand_dir();
    int k;
    k = $urandom_range(9);
    if (k == 0) return coord_t'(0);
    if (k == 1) return coord_t'($urandom);
    if (k == 2) return coord_t'($urandom_range(1) ? 1 : -1);
    return coord_t'(int'($urandom_range(1 << 18)) - (1 << 17));
  endfunction

  task automatic random_rays(int n);
    for (int i = 0; i < n; i++) begin
      send_ray(rand_coord(1), rand_coord(1), rand_coord(1), rand_dir(), rand_dir(), rand_dir());
    end
    in_valid <= 0;
  endtask

  task automatic random_box();
    coord_t a, b;
    coord_t lo[3], hi[3];
    for (int k = 0; k < 3; k++) begin
      a = coord_t'(int'($urandom_range(1 << 21)) - (1 << 20));
      b = coord_t'(int'($urandom_range(1 << 21)) - (1 << 20));
      if ($urandom_range(7) != 0 && a > b) begin
        lo[k] = b;
        hi[k] = a;
      end else begin
        lo[k] = a;
        hi[k] = b;
      end
    end
    set_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // reset box is a single point at the origin
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(1, 0, 0, 0, 0, 0);
    in_valid <= 0;
    drain();
    set_box(-32'sd65536, 32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536, 32'sd65536);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(32'sd65536, -32'sd65536, 32'sd65536, 0, 0, 0);
    send_ray(32'sd65537, 0, 0, 0, 0, 0);
    send_ray(-32'sd262144, 0, 0, 32'sd65536, 0, 0);
    send_ray(-32'sd262144, -32'sd262144, 0, 32'sd65536, 32'sd65536, 0);
    send_ray(-32'sd262144, 32'sd131072, 0, 32'sd65536, 32'sd65536, 0);
    send_ray(-32'sd131072, 0, -32'sd131072, 32'sd65536, 0, 32'sd65536);
    send_ray(32'sd262144, 0, 0, -32'sd65536, 0, 0);
    send_ray(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1);
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
    send_ray(0, 0, 0, 32'h7fffffff, -1, 1);
    send_ray(32'h7fffffff, 0, 32'h80000000, -1, 32'h7fffffff, 1);
    send_ray(32'sd3, 32'sd7, -32'sd5, 32'sd3, -32'sd7, 32'sd11);
    // box behind the ray still counts
    send_ray(32'sd262144, 0, 0, 32'sd65536, 0, 0);
    in_valid <= 0;
    drain();
    set_box(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff);
    send_ray(0, 0, 0, 1, 1, 1);
    send_ray(32'h7fffffff, 32'h80000000, 0, 1, -1, 0);
    send_ray(32'h80000000, 0, 0, 32'h7fffffff, 0, 0);
    in_valid <= 0;
    drain();
    // inverted box
    set_box(32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536, 32'sd65536, -32'sd65536);
    send_ray(0, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536);
    send_ray(0, 0, 0, 0, 32'sd65536, 32'sd65536);
    in_valid <= 0;
    drain();
    write_bound(CFG_IDX_W'(6), 32'sd12345);
    write_bound(CFG_IDX_W'(7), -32'sd1);
    cfg_valid <= 0;
    send_ray(0, 0, 0, 0, 32'sd65536, 32'sd65536);
    in_valid <= 0;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 19 : (ph == 1 ? 88 : 0);
      recv_idle_pct = ph == 0 ? 88 : (ph == 1 ? 19 : 0);
      for (int b = 0; b < 4; b++) begin
        random_box();
        random_rays(ph == 1 ? 90 : 150);
        if (b == 1) begin
          drain();
          random_rays(30);
        end
        drain();
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();

    $display("sent %0d rays over directed and random boxes, checked %0d hit results",
             rays_sent, sb.checked);
    if (sb.mismatches == 0 && sb.expected_hits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_hits.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
